>>> rtl/rlb_pkg.sv
// Package for the radix literal to binary parser.
// Holds the value width, radix-kind codes and the result struct; no dependencies.
package rlb_pkg;

    localparam int VALUE_BYTES = 8;
    localparam int ValueWidth  = 8 * VALUE_BYTES;
    localparam int OutWidth    = 64;

    // Bits of the 64-bit value port that the accumulator can reach.
    localparam logic [OutWidth-1:0] ValueMask =
        (VALUE_BYTES >= 8) ? {OutWidth{1'b1}}
                           : ((64'd1 << ValueWidth) - 64'd1);

    localparam logic [1:0] KIND_DEC = 2'd0;
    localparam logic [1:0] KIND_OCT = 2'd1;
    localparam logic [1:0] KIND_HEX = 2'd2;

    typedef enum logic [1:0] {
        RADIX_8,
        RADIX_10,
        RADIX_16
    } t_radix;

    typedef struct packed {
        logic [OutWidth-1:0] value;
        logic [1:0]          radix_kind;
        logic                bad_digit;
    } t_result;

endpackage

>>> rtl/rlb_digit_decode.sv
// Character to digit decoder for the literal parser.
// Depends on rlb_pkg for the radix type.
module rlb_digit_decode (
    input  logic [7:0]      i_ch,
    input  rlb_pkg::t_radix i_radix,
    output logic [3:0]      o_digit,
    output logic            o_ok
);

    logic       is_num;
    logic       is_lower;
    logic       is_upper;
    logic [7:0] off;

    always_comb begin
        is_num   = (i_ch >= 8'h30) && (i_ch <= 8'h39);
        is_lower = (i_ch >= 8'h61) && (i_ch <= 8'h66);
        is_upper = (i_ch >= 8'h41) && (i_ch <= 8'h46);
        if (is_num) begin
            off = i_ch - 8'h30;
        end else if (is_lower) begin
            off = i_ch - 8'h57;
        end else begin
            off = i_ch - 8'h37;
        end
        o_digit = off[3:0];
        case (i_radix)
            rlb_pkg::RADIX_8:  o_ok = is_num && (off[3:0] < 4'd8);
            rlb_pkg::RADIX_10: o_ok = is_num;
            rlb_pkg::RADIX_16: o_ok = is_num || is_lower || is_upper;
            default:           o_ok = 1'b0;
        endcase
    end

endmodule

>>> rtl/rlb_parser.sv
// Parser state (accumulator, phase, sticky error) and its per-character update.
// Depends on rlb_pkg and rlb_digit_decode.
module rlb_parser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic [7:0]       i_ch,
    input  logic             i_end_req,
    output rlb_pkg::t_result o_result
);

    typedef enum logic [2:0] {
        PH_START,
        PH_ZERO,
        PH_HEX,
        PH_OCT,
        PH_DEC
    } t_phase;

    t_phase                            r_phase, n_phase;
    logic [rlb_pkg::OutWidth-1:0]      r_acc, n_acc;
    logic                              r_err, n_err;
    logic                              take;
    rlb_pkg::t_radix                   radix;
    logic [3:0]                        digit;
    logic                              digit_ok;
    logic [rlb_pkg::OutWidth-1:0]      scaled;

    rlb_digit_decode u_decode (
        .i_ch    (i_ch),
        .i_radix (radix),
        .o_digit (digit),
        .o_ok    (digit_ok)
    );

    always_comb begin
        n_phase = r_phase;
        take    = 1'b1;
        radix   = rlb_pkg::RADIX_10;
        case (r_phase)
            PH_START: begin
                if (i_ch == 8'h30) begin
                    n_phase = PH_ZERO;
                    take    = 1'b0;
                end else begin
                    n_phase = PH_DEC;
                end
            end
            PH_ZERO: begin
                radix = rlb_pkg::RADIX_8;
                if (i_ch == 8'h78 || i_ch == 8'h58) begin
                    n_phase = PH_HEX;
                    take    = 1'b0;
                end else begin
                    n_phase = PH_OCT;
                end
            end
            PH_HEX:  radix = rlb_pkg::RADIX_16;
            PH_OCT:  radix = rlb_pkg::RADIX_8;
            default: n_phase = PH_DEC;
        endcase

        case (radix)
            rlb_pkg::RADIX_8:  scaled = r_acc << 3;
            rlb_pkg::RADIX_16: scaled = r_acc << 4;
            default:           scaled = (r_acc << 3) + (r_acc << 1);
        endcase

        n_acc = r_acc;
        n_err = r_err;
        if (take && !r_err) begin
            if (!digit_ok) begin
                n_err = 1'b1;
                n_acc = '0;
            end else begin
                n_acc = (scaled + {{(rlb_pkg::OutWidth-4){1'b0}}, digit})
                        & rlb_pkg::ValueMask;
            end
        end

        // An end request reports the current state and restarts the parser.
        if (i_end_req) begin
            n_phase = PH_START;
            n_acc   = '0;
            n_err   = 1'b0;
        end
    end

    always_comb begin
        o_result.bad_digit = r_err;
        o_result.value     = r_err ? '0 : (r_acc & rlb_pkg::ValueMask);
        case (r_phase)
            PH_HEX:          o_result.radix_kind = rlb_pkg::KIND_HEX;
            PH_ZERO, PH_OCT: o_result.radix_kind = rlb_pkg::KIND_OCT;
            default:         o_result.radix_kind = rlb_pkg::KIND_DEC;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_START;
            r_acc   <= '0;
            r_err   <= 1'b0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_err   <= n_err;
        end
    end

endmodule

>>> rtl/radix_literal_to_binary_top.sv
// Order: a request accepted into the input register updates the parser when it steps. An
// end request's result is loaded into the result register at the same edge as that step,
// so it shows on the output from the result register until it is taken.
// Throughput: one request per cycle while no end request stalls; the input register and
// the result register let a new request enter while a result waits to be taken.
// Reset: synchronous, active low; clears the parser to its start phase and
// empties both registers.
module radix_literal_to_binary_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_ch,
    input  logic        i_end_req,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [63:0] o_value,
    output logic [1:0]  o_radix_kind,
    output logic        o_bad_digit
);

    logic             r_in_valid;
    logic [7:0]       r_in_ch;
    logic             r_in_end;
    logic             r_out_valid;
    rlb_pkg::t_result r_out;
    rlb_pkg::t_result result;
    logic             step;

    // A character request always proceeds; an end request waits for a free slot.
    assign step    = r_in_valid && (!r_in_end || !r_out_valid || i_ready);
    assign o_ready = !r_in_valid || step;

    rlb_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (step),
        .i_ch      (r_in_ch),
        .i_end_req (r_in_end),
        .o_result  (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_in_ch  <= i_ch;
            r_in_end <= i_end_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step && r_in_end) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
        if (step && r_in_end) begin
            r_out <= result;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_value      = r_out.value;
    assign o_radix_kind = r_out.radix_kind;
    assign o_bad_digit  = r_out.bad_digit;

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_bad_digit |-> o_value == '0)
        else $error("bad digit result carries a nonzero value");

    a_kind_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_radix_kind != 2'd3)
        else $error("radix kind out of range");

    a_value_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_value & ~rlb_pkg::ValueMask) == '0)
        else $error("value exceeds accumulator width");

    a_end_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && r_in_end && !r_out_valid |=> r_out_valid)
        else $error("end request did not reach the result register");

endmodule
